// ===== hdl/pta_pkg.sv =====
// shared types and constants for the pi controller with anti-windup
// used by pta_alu, pta_ctrl and pi_tustin_antiwindup_top; no dependencies
`default_nettype none

package pta_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int CSR_IDX_W     = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_CURRENT        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PREVIOUS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PREVIOUS_RECIP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT         = 3'd4;

   // limit_hit codes
   localparam logic [1:0] HIT_NONE = 2'd0;
   localparam logic [1:0] HIT_HIGH = 2'd1;
   localparam logic [1:0] HIT_LOW  = 2'd2;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type               op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-2:0]        gain_current;
      logic signed [DATA_W-1:0] gain_previous;
      logic signed [DATA_W-1:0] gain_previous_recip;
      logic signed [DATA_W-1:0] upper_limit;
      logic signed [DATA_W-1:0] lower_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/pi_tustin_antiwindup_top.sv =====
// Discrete PI controller, Tustin form, with clamped drive and
// back-calculation anti-windup, in signed fixed point (FRAC_BITS fraction).
// Request channel (req_valid/req_stall): mode, reference, measured.
// Mode 0 runs one control step, mode 1 clears the stored error and drive.
// Response channel (rsp_valid/rsp_stall): drive and limit_hit, one per item.
// Gains and limits are written through csr_write/csr_index/csr_wdata; the
// user must do so only while no item is in flight, which the block does not enforce.
// One saturating add/subtract/multiply unit is shared by every operation,
// stepped by a sequencer one operation per cycle; req_stall is high from
// acceptance until the result is moved into the output register.
// Indexes above four are ignored. A clamped item passes ST_D2, ST_BACK and
// ST_CAP after ST_CLAMP; a clear goes straight from ST_IDLE to ST_DONE.
// The output register holds a result while rsp_stall is high; the next item
// is accepted meanwhile and waits at its end until the register frees.
// Synchronous reset clears the stored error, drive and the configuration
// registers to zero and empties the output.
// Depends on pta_pkg, pta_alu and pta_ctrl.
`default_nettype none

module pi_tustin_antiwindup_top #(
   parameter int FRAC_BITS = pta_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [pta_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pta_pkg::DATA_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic signed [pta_pkg::DATA_W-1:0]    req_reference,
   input  logic signed [pta_pkg::DATA_W-1:0]    req_measured,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pta_pkg::DATA_W-1:0]    rsp_drive,
   output logic [1:0]                           rsp_limit_hit
);
   import pta_pkg::*;

   cfg_type                  cfg_ff, cfg_in;
   alu_req_type              alu_req;
   logic signed [DATA_W-1:0] alu_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_CURRENT:        cfg_in.gain_current        = csr_wdata[DATA_W-2:0];
            CSR_GAIN_PREVIOUS:       cfg_in.gain_previous       = $signed(csr_wdata);
            CSR_GAIN_PREVIOUS_RECIP: cfg_in.gain_previous_recip = $signed(csr_wdata);
            CSR_UPPER_LIMIT:         cfg_in.upper_limit         = $signed(csr_wdata);
            CSR_LOWER_LIMIT:         cfg_in.lower_limit         = $signed(csr_wdata);
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pta_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_reference (req_reference),
      .req_measured  (req_measured),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive     (rsp_drive),
      .rsp_limit_hit (rsp_limit_hit),
      .alu_req       (alu_req),
      .alu_result    (alu_result)
   );

   pta_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock      (clock),
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

endmodule

`default_nettype wire

// ===== hdl/pta_alu.sv =====
// shared saturating add, subtract and fixed-point multiply unit
// one operation per cycle, result registered; depends on pta_pkg
`default_nettype none

module pta_alu #(
   parameter int FRAC_BITS = pta_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  pta_pkg::alu_req_type            alu_req,
   output logic signed [pta_pkg::DATA_W-1:0] alu_result
);
   import pta_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(SAT_MAX);
   localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(SAT_MIN);

   logic signed [PROD_W-1:0] product;
   logic signed [PROD_W-1:0] product_shifted;
   logic signed [DATA_W:0]   sum;
   logic signed [DATA_W-1:0] result_in;
   logic signed [DATA_W-1:0] result_ff;

   always_comb begin
      product = $signed(alu_req.a) * $signed(alu_req.b);
      // arithmetic shift rounds toward minus infinity
      product_shifted = product >>> FRAC_BITS;
      sum = '0;
      result_in = '0;
      unique case (alu_req.op)
         ALU_ADD, ALU_SUB: begin
            if (alu_req.op == ALU_ADD) begin
               sum = {alu_req.a[DATA_W-1], alu_req.a} + {alu_req.b[DATA_W-1], alu_req.b};
            end else begin
               sum = {alu_req.a[DATA_W-1], alu_req.a} - {alu_req.b[DATA_W-1], alu_req.b};
            end
            if (sum[DATA_W] != sum[DATA_W-1]) begin
               result_in = sum[DATA_W] ? SAT_MIN : SAT_MAX;
            end else begin
               result_in = sum[DATA_W-1:0];
            end
         end
         ALU_MUL: begin
            if (product_shifted > PROD_MAX) begin
               result_in = SAT_MAX;
            end else if (product_shifted < PROD_MIN) begin
               result_in = SAT_MIN;
            end else begin
               result_in = product_shifted[DATA_W-1:0];
            end
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign alu_result = result_ff;

endmodule

`default_nettype wire

// ===== hdl/pta_ctrl.sv =====
// sequencer of the pi controller: operand selection for the shared unit,
// clamping, controller state and the output register; depends on pta_pkg
`default_nettype none

module pta_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  pta_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic signed [pta_pkg::DATA_W-1:0] req_reference,
   input  logic signed [pta_pkg::DATA_W-1:0] req_measured,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pta_pkg::DATA_W-1:0] rsp_drive,
   output logic [1:0]                        rsp_limit_hit,
   output pta_pkg::alu_req_type              alu_req,
   input  logic signed [pta_pkg::DATA_W-1:0] alu_result
);
   import pta_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_ERR   = 11'b000_0000_0010,
      ST_P1    = 11'b000_0000_0100,
      ST_P0    = 11'b000_0000_1000,
      ST_SUM   = 11'b000_0001_0000,
      ST_ACC   = 11'b000_0010_0000,
      ST_CLAMP = 11'b000_0100_0000,
      ST_D2    = 11'b000_1000_0000,
      ST_BACK  = 11'b001_0000_0000,
      ST_CAP   = 11'b010_0000_0000,
      ST_DONE  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] ref_ff, ref_in;
   logic signed [DATA_W-1:0] meas_ff, meas_in;
   logic signed [DATA_W-1:0] e_ff, e_in;
   logic signed [DATA_W-1:0] p1_ff, p1_in;
   logic signed [DATA_W-1:0] p0_ff, p0_in;
   logic signed [DATA_W-1:0] u_ff, u_in;
   logic [1:0]               hit_ff, hit_in;
   logic signed [DATA_W-1:0] new_pe_ff, new_pe_in;
   logic signed [DATA_W-1:0] pe_ff, pe_in;
   logic signed [DATA_W-1:0] pd_ff, pd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic [1:0]               rsp_hit_ff, rsp_hit_in;

   always_comb begin
      state_in     = state_ff;
      ref_in       = ref_ff;
      meas_in      = meas_ff;
      e_in         = e_ff;
      p1_in        = p1_ff;
      p0_in        = p0_ff;
      u_in         = u_ff;
      hit_in       = hit_ff;
      new_pe_in    = new_pe_ff;
      pe_in        = pe_ff;
      pd_in        = pd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_hit_in   = rsp_hit_ff;
      alu_req.op   = ALU_ADD;
      alu_req.a    = '0;
      alu_req.b    = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ref_in  = req_reference;
               meas_in = req_measured;
               if (req_mode) begin
                  // clear: zero drive, zero state
                  u_in      = '0;
                  hit_in    = HIT_NONE;
                  new_pe_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ref_ff;
            alu_req.b  = meas_ff;
            state_in   = ST_P1;
         end
         ST_P1: begin
            e_in       = alu_result;
            alu_req.op = ALU_MUL;
            alu_req.a  = cfg.gain_previous;
            alu_req.b  = pe_ff;
            state_in   = ST_P0;
         end
         ST_P0: begin
            p1_in      = alu_result;
            alu_req.op = ALU_MUL;
            alu_req.a  = $signed({1'b0, cfg.gain_current});
            alu_req.b  = e_ff;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            p0_in      = alu_result;
            alu_req.op = ALU_ADD;
            alu_req.a  = alu_result;
            alu_req.b  = p1_ff;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = alu_result;
            alu_req.b  = pd_ff;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            // upper limit wins when the limits cross
            if (alu_result > cfg.upper_limit) begin
               u_in   = cfg.upper_limit;
               hit_in = HIT_HIGH;
            end else if (alu_result < cfg.lower_limit) begin
               u_in   = cfg.lower_limit;
               hit_in = HIT_LOW;
            end else begin
               u_in   = alu_result;
               hit_in = HIT_NONE;
            end
            alu_req.op = ALU_SUB;
            alu_req.a  = u_in;
            alu_req.b  = p0_ff;
            if (hit_in == HIT_NONE) begin
               new_pe_in = e_ff;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_D2;
            end
         end
         ST_D2: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = alu_result;
            alu_req.b  = pd_ff;
            state_in   = ST_BACK;
         end
         ST_BACK: begin
            // back-calculated past error
            alu_req.op = ALU_MUL;
            alu_req.a  = alu_result;
            alu_req.b  = cfg.gain_previous_recip;
            state_in   = ST_CAP;
         end
         ST_CAP: begin
            new_pe_in = alu_result;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = u_ff;
               rsp_hit_in   = hit_ff;
               pe_in        = new_pe_ff;
               pd_in        = u_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pe_ff        <= '0;
         pd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pe_ff        <= pe_in;
         pd_ff        <= pd_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff       <= ref_in;
      meas_ff      <= meas_in;
      e_ff         <= e_in;
      p1_ff        <= p1_in;
      p0_ff        <= p0_in;
      u_ff         <= u_in;
      hit_ff       <= hit_in;
      new_pe_ff    <= new_pe_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_limit_hit = rsp_hit_ff;

endmodule

`default_nettype wire
